// ===== hdl/md4m_pkg.sv =====
// md4m_pkg: shared types, constants and mixing functions of the md4 matcher
// no dependencies
`timescale 1ns / 1ps

package md4m_pkg;

    localparam int PASSWORD_LENGTH = 6;
    localparam int PW_CHARS        = (PASSWORD_LENGTH < 7) ? PASSWORD_LENGTH : 7;
    localparam logic [31:0] BIT_LEN = 32'(8 * PASSWORD_LENGTH);
    localparam int NUM_STEPS       = 41;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] K2   = 32'h5A827999;
    localparam logic [31:0] K3   = 32'h6ED9EBA1;

    // round codes
    localparam logic [1:0] RND_F = 2'd0;
    localparam logic [1:0] RND_G = 2'd1;
    localparam logic [1:0] RND_H = 2'd2;

    // register indexes
    localparam logic [2:0] REG_TGT_LO = 3'd0;
    localparam logic [2:0] REG_TGT_HI = 3'd1;
    localparam logic [2:0] REG_CT0    = 3'd2;
    localparam logic [2:0] REG_CT1    = 3'd3;
    localparam logic [2:0] REG_CT2    = 3'd4;
    localparam logic [2:0] REG_CT3    = 3'd5;

    // one pipeline slot
    typedef struct packed {
        logic             vld;
        logic [29:0]      id;
        logic [31:0]      m0;
        logic [31:0]      m1;
        logic [3:0][31:0] r;
    } md4m_st_t;

    function automatic logic [31:0] mix(input logic [1:0] rnd, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
        logic [31:0] res;
        unique case (rnd)
            RND_F:   res = (x & y) | (~x & z);
            RND_G:   res = (x & y) | (x & z) | (y & z);
            default: res = x ^ y ^ z;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] w;
        w = {x, x} << s;
        return w[63:32];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] w;
        w = {x, x} >> s;
        return w[31:0];
    endfunction

    function automatic logic [4:0] r3_shift(input logic [1:0] j);
        logic [4:0] s;
        unique case (j)
            2'd0:    s = 5'd3;
            2'd1:    s = 5'd9;
            2'd2:    s = 5'd11;
            default: s = 5'd15;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/md4m_msg.sv =====
// md4m_msg: first pipeline stage, builds the password block words
// depends on md4m_pkg
`timescale 1ns / 1ps

module md4m_msg
    import md4m_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld,
    input  logic [29:0]      id,
    input  logic [255:0]     char_table,
    output md4m_st_t         st_reg
);

    logic [63:0] pw;
    logic [39:0] id_ext;
    md4m_st_t    st_next;

    // character lookup and marker byte
    always_comb
    begin
        logic [4:0] k;
        id_ext = {10'd0, id};
        pw     = '0;
        for (int i = 0; i < PW_CHARS; i++)
        begin
            k = id_ext[5*i +: 5];
            pw[8*i +: 8] = char_table[{k, 3'b000} +: 8];
        end
        if (PW_CHARS < 8)
        begin
            pw[8*PW_CHARS +: 8] = 8'h80;
        end
        st_next.vld = vld;
        st_next.id  = id;
        st_next.m0  = pw[31:0];
        st_next.m1  = pw[63:32];
        st_next.r   = {IV_D, IV_C, IV_B, IV_A};
    end

    // stage register, valid bit and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (en)
        begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== hdl/md4m_step.sv =====
// md4m_step: one registered md4 step, step number tied at the instance
// depends on md4m_pkg
`timescale 1ns / 1ps

module md4m_step
    import md4m_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic [5:0] step,
    input  md4m_st_t  st_in,
    output md4m_st_t  st_reg
);

    logic [1:0]  rnd;
    logic [3:0]  j;
    logic [3:0]  widx;
    logic [1:0]  t;
    logic [31:0] x;
    logic [31:0] kc;
    logic [4:0]  s;
    logic [31:0] f;
    md4m_st_t    st_next;

    assign rnd = step[5:4];
    assign j   = step[3:0];
    assign t   = 2'd0 - j[1:0];

    // message word, constant and rotation of this step
    always_comb
    begin
        unique case (rnd)
            RND_F:
            begin
                widx = j;
                kc   = '0;
                unique case (j[1:0])
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd7;
                    2'd2:    s = 5'd11;
                    default: s = 5'd19;
                endcase
            end
            RND_G:
            begin
                widx = {j[1:0], j[3:2]};
                kc   = K2;
                unique case (j[1:0])
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd5;
                    2'd2:    s = 5'd9;
                    default: s = 5'd13;
                endcase
            end
            default:
            begin
                widx = {j[0], j[1], j[2], j[3]};
                kc   = K3;
                s    = r3_shift(j[1:0]);
            end
        endcase
        unique case (widx)
            4'd0:    x = st_in.m0;
            4'd1:    x = st_in.m1;
            4'd14:   x = BIT_LEN;
            default: x = '0;
        endcase
    end

    // step datapath
    always_comb
    begin
        f = mix(rnd, st_in.r[t + 2'd1], st_in.r[t + 2'd2], st_in.r[t + 2'd3]);
        st_next      = st_in;
        st_next.r[t] = rotl(st_in.r[t] + f + x + kc, s);
    end

    // stage register, valid bit and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (en)
        begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== hdl/md4m_derive.sv =====
// md4m_derive: target registers and the sequencer that reduces the target
// depends on md4m_pkg
`timescale 1ns / 1ps

module md4m_derive
    import md4m_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [2:0]       wr_index,
    input  logic [63:0]      wr_data,
    output logic             busy,
    output logic [3:0][31:0] tgt_reg
);

    logic [63:0] lo_reg, hi_reg;
    logic        busy_reg;
    logic [2:0]  cnt_reg;
    logic [3:0]  j;
    logic [1:0]  t;
    logic [31:0] f;
    logic [3:0][31:0] tgt_next;

    assign busy = busy_reg;
    assign j    = 4'd0 - {1'b0, cnt_reg};
    assign t    = 2'd0 - j[1:0];

    // load target minus the IV, then undo one round-3 step per cycle, j = 15 down to 9
    always_comb
    begin
        tgt_next = tgt_reg;
        f = mix(RND_H, tgt_reg[t + 2'd1], tgt_reg[t + 2'd2], tgt_reg[t + 2'd3]);
        if (cnt_reg == 3'd0)
        begin
            tgt_next[0] = lo_reg[31:0]  - IV_A;
            tgt_next[1] = lo_reg[63:32] - IV_B;
            tgt_next[2] = hi_reg[31:0]  - IV_C;
            tgt_next[3] = hi_reg[63:32] - IV_D;
        end
        else
        begin
            tgt_next[t] = rotr(tgt_reg[t], r3_shift(j[1:0])) - f - K3;
        end
    end

    // target registers and sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg   <= '0;
            hi_reg   <= '0;
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (wr && (wr_index == REG_TGT_LO || wr_index == REG_TGT_HI))
        begin
            if (wr_index == REG_TGT_LO)
            begin
                lo_reg <= wr_data;
            end
            else
            begin
                hi_reg <= wr_data;
            end
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + 3'd1;
            busy_reg <= (cnt_reg != 3'd7);
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            tgt_reg <= tgt_next;
        end
    end

endmodule

// ===== hdl/md4_short_password_matcher_core.sv =====
// input to result: message stage, 41 md4 step stages, compare stage; one item per
// cycle, set by one step per stage, while the output is not stalled; after reset
// and after each target write the block takes no item while the reduced target
// is recomputed; rst_n clears valid bits, config and stage registers
// md4_short_password_matcher_core: top level, depends on md4m_pkg and submodules
`timescale 1ns / 1ps

module md4_short_password_matcher_core
    import md4m_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // candidate_id[29:0], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // tested_id[29:0], found[30], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic             adv;
    logic             busy;
    logic             cfg_wr;
    logic [3:0][31:0] tgt;
    logic [3:0][63:0] ct_reg;
    md4m_st_t         stage [0:NUM_STEPS];
    logic             out_vld_reg;
    logic [29:0]      out_id_reg;
    logic             out_found_reg;

    assign cfg_ready     = 1'b1;
    assign cfg_wr        = cfg_valid & cfg_ready;
    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv && !busy;

    // character table registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ct_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_CT0: ct_reg[0] <= cfg_data;
                REG_CT1: ct_reg[1] <= cfg_data;
                REG_CT2: ct_reg[2] <= cfg_data;
                REG_CT3: ct_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    md4m_derive u_derive (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (cfg_wr),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .busy     (busy),
        .tgt_reg  (tgt)
    );

    md4m_msg u_msg (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .vld        (s_axis_tvalid && s_axis_tready),
        .id         (s_axis_tdata[29:0]),
        .char_table (ct_reg),
        .st_reg     (stage[0])
    );

    // md4 step pipeline
    for (genvar n = 0; n < NUM_STEPS; n++)
    begin : g_step
        md4m_step u_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (adv),
            .step   (6'(n)),
            .st_in  (stage[n]),
            .st_reg (stage[n+1])
        );
    end

    // compare and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= stage[NUM_STEPS].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_id_reg    <= stage[NUM_STEPS].id;
            out_found_reg <= (stage[NUM_STEPS].r == tgt);
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, out_found_reg, out_id_reg};

    // checks
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready)
        else $error("item accepted while target derivation runs");

    a_tgt_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && (cfg_index == REG_TGT_LO || cfg_index == REG_TGT_HI)) |=> busy)
        else $error("target write did not start derivation");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(stage[NUM_STEPS].vld) && $stable(stage[0].vld))
        else $error("pipeline moved during output stall");

endmodule
